// ----- src/ucs_pkg.sv -----
// Package for the URI component splitter: step encoding, component codes,
// character constants and the hex digit decoder. No dependencies.
package ucs_pkg;

  localparam int IDX_W    = 6;
  localparam int NPARTS   = 8;
  localparam logic [IDX_W-1:0] NONE_IDX = 6'd63;
  localparam logic [5:0]  ITEM_CAP = 6'd63;

  localparam logic [3:0] COMP_SCHEME = 4'd0;
  localparam logic [3:0] COMP_USER   = 4'd1;
  localparam logic [3:0] COMP_AUTH   = 4'd2;
  localparam logic [3:0] COMP_PASS   = 4'd3;
  localparam logic [3:0] COMP_HOST   = 4'd4;
  localparam logic [3:0] COMP_PATH   = 4'd5;
  localparam logic [3:0] COMP_QUERY  = 4'd6;
  localparam logic [3:0] COMP_ANCHOR = 4'd7;
  localparam logic [3:0] COMP_SUM    = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [4:0] {
    S_LOAD, S_START,
    A_RUN, A_SL1, A_SL2,
    B_SL1, B_SL2, B_SKIP, B_USER, B_AUTH, B_PW, B_PW2,
    C_USER, C_AUTH,
    H_HOST, H_PORT, H_PATH, H_QUERY, H_ANCHOR, H_REST,
    E_PART, E_C0, E_C1, E_C2, E_SUM
  } ucs_step_t;

  // bit 4: valid hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

// ----- src/ucs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/uri_component_splitter.sv -----
// URI component splitter top level: loads a string, splits it and percent-decodes all components but auth and query.
// Depends on ucs_pkg and ucs_ram.
//
//  channel | ports                                      | direction
//  in      | in_valid, in_stall, in_byte, in_last       | bytes of one URI string
//  out     | out_valid, out_stall, out_byte, out_*      | tagged component bytes, summary
//
// Loading takes one byte per cycle while in_stall is low. After the last byte the split walks
// the string through the single read port of the text store. rst_n is synchronous and
// clears all control state. in_stall is high from the last byte until the summary
// transaction is registered; out_stall holds the sequencer while a result waits in the
// output register.
module uri_component_splitter
  import ucs_pkg::*;
#(
  parameter int MAX_CHARS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic [3:0]  out_component,
  output logic        out_component_end,
  output logic [15:0] out_port_value,
  output logic        out_has_port,
  output logic        out_truncated,
  output logic        out_last
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam logic [IDX_W-1:0] MAXC = IDX_W'(MAX_CHARS);

  ucs_step_t step_r, step_nxt;
  logic             ph_r, ph_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] at_r, at_nxt, slash_r, slash_nxt, colon_r, colon_nxt, zero_r, zero_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] p_r, p_nxt, s_r, s_nxt, i_r, i_nxt;
  logic             tgt_r, tgt_nxt;
  logic [3:0]       comp_r, comp_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [15:0]      port_r, port_nxt;
  logic             hport_r, hport_nxt, cut_r, cut_nxt;
  logic [5:0]       nout_r, nout_nxt;
  logic [IDX_W-1:0] part_s_r [NPARTS];
  logic [IDX_W-1:0] part_s_nxt [NPARTS];
  logic [IDX_W-1:0] part_e_r [NPARTS];
  logic [IDX_W-1:0] part_e_nxt [NPARTS];
  logic [NPARTS-1:0] part_on_r, part_on_nxt, part_raw_r, part_raw_nxt;

  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        obv_r, obv_nxt, oend_r, oend_nxt, ohp_r, ohp_nxt, otr_r, otr_nxt;
  logic        olast_r, olast_nxt;
  logic [3:0]  ocomp_r, ocomp_nxt;
  logic [15:0] oport_r, oport_nxt;

  logic [7:0]       rdata, c;
  logic [IDX_W-1:0] str_len;
  logic             in_acc, out_free;

  ucs_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_text (
    .clk   (clk),
    .we    (in_acc && (cnt_r < MAXC)),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_byte),
    .raddr (p_r[AW-1:0]),
    .rdata (rdata)
  );

  assign in_stall = (step_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign str_len  = (zero_r < cnt_r) ? zero_r : cnt_r;
  assign c        = (p_r < str_len) ? rdata : CH_NUL;

  always_comb begin
    logic             at_ok, colon_ok, stop, tail_inc, want_put, marker, is_end;
    logic [7:0]       put_byte;
    logic             put_bv;
    logic [IDX_W-1:0] ni, pe, pt;
    logic [2:0]       tk;
    logic [19:0]      wide;
    logic [4:0]       hv;
    ucs_step_t        tail;

    step_nxt = step_r;  cnt_nxt = cnt_r;  at_nxt = at_r;  slash_nxt = slash_r;
    colon_nxt = colon_r;  zero_nxt = zero_r;  ovf_nxt = ovf_r;
    p_nxt = p_r;  s_nxt = s_r;  i_nxt = i_r;  tgt_nxt = tgt_r;  comp_nxt = comp_r;
    hi_nxt = hi_r;  port_nxt = port_r;  hport_nxt = hport_r;  cut_nxt = cut_r;
    nout_nxt = nout_r;  part_s_nxt = part_s_r;  part_e_nxt = part_e_r;
    part_on_nxt = part_on_r;  part_raw_nxt = part_raw_r;
    ov_nxt = ov_r && out_stall;  ob_nxt = ob_r;  obv_nxt = obv_r;  ocomp_nxt = ocomp_r;
    oend_nxt = oend_r;  oport_nxt = oport_r;  ohp_nxt = ohp_r;  otr_nxt = otr_r;
    olast_nxt = olast_r;

    at_ok    = at_r < str_len;
    colon_ok = (colon_r < str_len) && !((slash_r < str_len) && (slash_r < colon_r));
    want_put = 1'b0;  marker = 1'b0;  put_byte = CH_NUL;  put_bv = 1'b1;
    ni = i_r;  tk = 3'd0;  stop = 1'b0;  is_end = 1'b0;
    hv = hex_val(c);
    wide = ({4'd0, port_r} << 3) + ({4'd0, port_r} << 1) + 20'(c - CH_ZERO);
    pt = p_r + IDX_W'(1);

    tail_inc = 1'b0;
    if (c == CH_SLASH) tail = H_PATH;
    else if (c == CH_QUEST) begin
      tail = H_QUERY;
      tail_inc = 1'b1;
    end else if (c == CH_HASH) tail = H_ANCHOR;
    else if (c != CH_NUL) tail = H_REST;
    else tail = E_PART;
    pe = tail_inc ? pt : p_r;

    case (step_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < MAXC) begin
            if (in_byte == CH_AT && at_r == NONE_IDX) at_nxt = cnt_r;
            if (in_byte == CH_SLASH && slash_r == NONE_IDX) slash_nxt = cnt_r;
            if (in_byte == CH_COLON && colon_r == NONE_IDX) colon_nxt = cnt_r;
            if (in_byte == CH_NUL && zero_r == NONE_IDX) zero_nxt = cnt_r;
            cnt_nxt = cnt_r + IDX_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) step_nxt = S_START;
        end
      end
      S_START: begin
        part_on_nxt = '0;  port_nxt = '0;  hport_nxt = 1'b0;  cut_nxt = 1'b0;
        nout_nxt = '0;  comp_nxt = COMP_SCHEME;  tgt_nxt = 1'b0;
        p_nxt = '0;  s_nxt = '0;
        if (colon_ok && !at_ok) step_nxt = A_RUN;
        else if (colon_ok && at_ok && colon_r < at_r) begin
          p_nxt = colon_r + IDX_W'(1);
          step_nxt = B_SL1;
        end else if (at_ok) step_nxt = C_USER;
        else step_nxt = H_HOST;
      end
      A_RUN: if (ph_r) begin
        if (c == CH_NUL || c == CH_COLON) begin
          stop = 1'b1;  tk = COMP_SCHEME[2:0];
          p_nxt = pt;  step_nxt = A_SL1;
        end else p_nxt = pt;
      end
      A_SL1, A_SL2: if (ph_r) begin
        if (c == CH_SLASH) p_nxt = pt;
        if (c == CH_SLASH && step_r == A_SL1) step_nxt = A_SL2;
        else begin
          s_nxt = (c == CH_SLASH) ? pt : p_r;
          step_nxt = H_HOST;
        end
      end
      B_SL1: if (ph_r) begin
        if (c == CH_SLASH) begin
          p_nxt = pt;  step_nxt = B_SL2;
        end else begin
          p_nxt = '0;  s_nxt = '0;  step_nxt = B_USER;
        end
      end
      B_SL2: if (ph_r) begin
        if (c == CH_SLASH) begin
          part_s_nxt[COMP_SCHEME[2:0]] = '0;
          part_e_nxt[COMP_SCHEME[2:0]] = colon_r;
          part_on_nxt[COMP_SCHEME[2:0]] = 1'b1;
          part_raw_nxt[COMP_SCHEME[2:0]] = 1'b0;
          p_nxt = colon_r + IDX_W'(1);  step_nxt = B_SKIP;
        end else begin
          p_nxt = '0;  s_nxt = '0;  step_nxt = B_USER;
        end
      end
      B_SKIP: if (ph_r) begin
        if (c == CH_SLASH) p_nxt = pt;
        else begin
          tgt_nxt = 1'b1;  s_nxt = p_r;  step_nxt = B_USER;
        end
      end
      B_USER, B_AUTH, B_PW, B_PW2, C_USER, C_AUTH: if (ph_r) begin
        stop = (c == CH_NUL) || (c == CH_AT);
        if ((step_r == B_USER || step_r == C_USER) && c == CH_SEMI) stop = 1'b1;
        if (step_r != B_PW2 && step_r != C_USER && step_r != C_AUTH && c == CH_COLON)
          stop = 1'b1;
        if (step_r == B_USER && c == CH_COLON) stop = 1'b1;
        if (!stop) p_nxt = pt;
        else begin
          case (step_r)
            B_USER:  tk = tgt_r ? COMP_USER[2:0] : COMP_SCHEME[2:0];
            B_AUTH, C_AUTH: tk = COMP_AUTH[2:0];
            C_USER:  tk = COMP_USER[2:0];
            default: tk = COMP_PASS[2:0];
          endcase
          s_nxt = p_r;
          if ((step_r == B_USER || step_r == C_USER) && c == CH_SEMI) begin
            p_nxt = pt;  s_nxt = pt;
            step_nxt = (step_r == B_USER) ? B_AUTH : C_AUTH;
          end else if ((step_r == B_USER || step_r == B_AUTH) && c == CH_COLON) begin
            p_nxt = pt;  s_nxt = pt;  step_nxt = B_PW;
          end else if (step_r == B_PW && c == CH_COLON) begin
            part_s_nxt[COMP_USER[2:0]] = part_s_r[COMP_AUTH[2:0]];
            part_e_nxt[COMP_USER[2:0]] = part_e_r[COMP_AUTH[2:0]];
            part_on_nxt[COMP_USER[2:0]] = part_on_r[COMP_AUTH[2:0]];
            part_raw_nxt[COMP_USER[2:0]] = part_raw_r[COMP_AUTH[2:0]];
            p_nxt = pt;  s_nxt = pt;  step_nxt = B_PW2;
          end else if (c == CH_NUL &&
                       (step_r == B_USER || step_r == B_AUTH ||
                        step_r == B_PW || step_r == B_PW2)) begin
            step_nxt = E_PART;
          end else begin
            if (c == CH_AT) begin
              p_nxt = pt;  s_nxt = pt;
            end
            step_nxt = H_HOST;
          end
        end
      end
      H_HOST: if (ph_r) begin
        if (c == CH_NUL || c == CH_COLON || c == CH_SLASH || c == CH_QUEST || c == CH_HASH)
        begin
          stop = 1'b1;  tk = COMP_HOST[2:0];
          if (c == CH_COLON) begin
            p_nxt = pt;  hport_nxt = 1'b1;  step_nxt = H_PORT;
          end else begin
            p_nxt = pe;  s_nxt = pe;  step_nxt = tail;
          end
        end else p_nxt = pt;
      end
      H_PORT: if (ph_r) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          port_nxt = (wide > 20'd65535) ? 16'hFFFF : wide[15:0];
          p_nxt = pt;
        end else begin
          p_nxt = pe;  s_nxt = pe;  step_nxt = tail;
        end
      end
      H_PATH, H_QUERY, H_ANCHOR, H_REST: if (ph_r) begin
        stop = (c == CH_NUL);
        if (step_r != H_ANCHOR && (c == CH_QUEST || c == CH_HASH)) stop = 1'b1;
        if (step_r == H_QUERY && c == CH_QUEST) stop = 1'b0;
        if (!stop) p_nxt = pt;
        else begin
          case (step_r)
            H_QUERY:  tk = COMP_QUERY[2:0];
            H_ANCHOR: tk = COMP_ANCHOR[2:0];
            default:  tk = COMP_PATH[2:0];
          endcase
          if (step_r == H_REST) step_nxt = E_PART;
          else begin
            p_nxt = pe;  s_nxt = pe;  step_nxt = tail;
          end
        end
      end
      E_PART: begin
        if (comp_r == COMP_SUM) step_nxt = E_SUM;
        else if (!part_on_r[comp_r[2:0]]) comp_nxt = comp_r + 4'd1;
        else if (part_s_r[comp_r[2:0]] >= part_e_r[comp_r[2:0]]) begin
          want_put = 1'b1;  marker = 1'b1;  put_bv = 1'b0;
        end else begin
          i_nxt = part_s_r[comp_r[2:0]];  p_nxt = part_s_r[comp_r[2:0]];
          step_nxt = E_C0;
        end
      end
      E_C0: if (ph_r) begin
        if (!part_raw_r[comp_r[2:0]] && c == CH_PCT) begin
          p_nxt = i_r + IDX_W'(1);  step_nxt = E_C1;
        end else begin
          want_put = 1'b1;  put_byte = c;  ni = i_r + IDX_W'(1);
        end
      end
      E_C1: if (ph_r) begin
        if (hv[4]) begin
          hi_nxt = hv[3:0];  p_nxt = i_r + IDX_W'(2);  step_nxt = E_C2;
        end else begin
          want_put = 1'b1;  put_byte = CH_PCT;  ni = i_r + IDX_W'(1);
        end
      end
      E_C2: if (ph_r) begin
        want_put = 1'b1;
        if (hv[4]) begin
          put_byte = {hi_r, hv[3:0]};  ni = i_r + IDX_W'(3);
        end else begin
          put_byte = CH_PCT;  ni = i_r + IDX_W'(1);
        end
      end
      E_SUM: begin
        if (out_free) begin
          ov_nxt = 1'b1;  ob_nxt = CH_NUL;  obv_nxt = 1'b0;  ocomp_nxt = COMP_SUM;
          oend_nxt = 1'b1;  oport_nxt = port_r;  ohp_nxt = hport_r;
          otr_nxt = ovf_r || cut_r;  olast_nxt = 1'b1;
          cnt_nxt = '0;  at_nxt = NONE_IDX;  slash_nxt = NONE_IDX;  colon_nxt = NONE_IDX;
          zero_nxt = NONE_IDX;  ovf_nxt = 1'b0;
          step_nxt = S_LOAD;
        end
      end
      default: step_nxt = S_LOAD;
    endcase

    if (stop) begin
      part_s_nxt[tk] = s_r;
      part_e_nxt[tk] = p_r;
      part_on_nxt[tk] = 1'b1;
      part_raw_nxt[tk] = (tk == COMP_AUTH[2:0]) || (tk == COMP_QUERY[2:0]);
    end

    if (want_put) begin
      if (nout_r == ITEM_CAP) begin
        cut_nxt = 1'b1;  step_nxt = E_SUM;
      end else if (out_free) begin
        is_end = marker || (ni >= part_e_r[comp_r[2:0]]);
        ov_nxt = 1'b1;  ob_nxt = put_byte;  obv_nxt = put_bv;  ocomp_nxt = comp_r;
        oend_nxt = is_end || (nout_r == ITEM_CAP - 6'd1);
        oport_nxt = '0;  ohp_nxt = 1'b0;  otr_nxt = 1'b0;  olast_nxt = 1'b0;
        nout_nxt = nout_r + 6'd1;
        if (is_end) begin
          comp_nxt = comp_r + 4'd1;  step_nxt = E_PART;
        end else begin
          i_nxt = ni;  p_nxt = ni;  step_nxt = E_C0;
        end
      end else begin
        step_nxt = step_r;  p_nxt = p_r;
      end
    end

    ph_nxt = (p_nxt == p_r) && (step_r != S_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_LOAD;  ph_r <= 1'b0;  cnt_r <= '0;
      at_r <= NONE_IDX;  slash_r <= NONE_IDX;  colon_r <= NONE_IDX;  zero_r <= NONE_IDX;
      ovf_r <= 1'b0;  ov_r <= 1'b0;  part_on_r <= '0;  comp_r <= '0;  nout_r <= '0;
      cut_r <= 1'b0;  hport_r <= 1'b0;  tgt_r <= 1'b0;
    end else begin
      step_r <= step_nxt;  ph_r <= ph_nxt;  cnt_r <= cnt_nxt;
      at_r <= at_nxt;  slash_r <= slash_nxt;  colon_r <= colon_nxt;  zero_r <= zero_nxt;
      ovf_r <= ovf_nxt;  ov_r <= ov_nxt;  part_on_r <= part_on_nxt;  comp_r <= comp_nxt;
      nout_r <= nout_nxt;  cut_r <= cut_nxt;  hport_r <= hport_nxt;  tgt_r <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;  s_r <= s_nxt;  i_r <= i_nxt;  hi_r <= hi_nxt;  port_r <= port_nxt;
    part_s_r <= part_s_nxt;  part_e_r <= part_e_nxt;  part_raw_r <= part_raw_nxt;
    ob_r <= ob_nxt;  obv_r <= obv_nxt;  ocomp_r <= ocomp_nxt;  oend_r <= oend_nxt;
    oport_r <= oport_nxt;  ohp_r <= ohp_nxt;  otr_r <= otr_nxt;  olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_byte_valid    = obv_r;
  assign out_component     = ocomp_r;
  assign out_component_end = oend_r;
  assign out_port_value    = oport_r;
  assign out_has_port      = ohp_r;
  assign out_truncated     = otr_r;
  assign out_last          = olast_r;

`ifndef SYNTHESIS
  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_component == COMP_SUM)
    else $error("last transaction is not a summary");
  a_summary_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_component == COMP_SUM |-> out_component_end && out_last)
    else $error("summary without end marks");
  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_component_end)
    else $error("empty marker without component end");
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != S_LOAD |-> in_stall)
    else $error("input taken while splitting");
  a_last_byte_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not held after last byte");
`endif

endmodule
